FILE: rtl/bsp_pkg.sv
// ============================================================================
// bsp_pkg: shared types and constants of the slot pool
// Action and status codes, slot states and the slot table write request.
// ============================================================================
package bsp_pkg;

    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned DESC_W  = 16;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned MASK_W  = 32;

    // Descriptor value of a slot that holds no descriptor.
    localparam logic [DESC_W-1:0] DESC_NONE = '1;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [DESC_W-1:0] desc_t;

    typedef enum logic [2:0] {
        ACT_ALLOC = 3'd0,
        ACT_BIND  = 3'd1,
        ACT_FLAGS = 3'd2,
        ACT_CLOSE = 3'd3,
        ACT_SWEEP = 3'd4,
        ACT_FIND  = 3'd5,
        ACT_COUNT = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_MISSING   = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE   = 2'd0,
        SLOT_NEW    = 2'd1,
        SLOT_CLOSED = 2'd2
    } slot_state_t;

    // Write request into the slot table; state and descriptor write separately.
    typedef struct packed {
        logic        we_state;
        logic        we_desc;
        slot_idx_t   idx;
        slot_state_t state;
        desc_t       desc;
    } tbl_wr_t;

endpackage

FILE: rtl/bsp_req_if.sv
// ============================================================================
// bsp_req_if: request channel of the slot pool
// Valid/ready channel carrying one action request.
// ============================================================================
interface bsp_req_if;

    logic                  valid;
    logic                  ready;
    logic [2:0]            action;
    logic [4:0]            slot;
    logic signed [15:0]    descriptor;
    logic                  write_pending_in;
    logic                  ws_active_in;
    logic                  read_paused_in;

    modport source (
        output valid, action, slot, descriptor,
               write_pending_in, ws_active_in, read_paused_in,
        input  ready
    );

    modport sink (
        input  valid, action, slot, descriptor,
               write_pending_in, ws_active_in, read_paused_in,
        output ready
    );

endinterface

FILE: rtl/bsp_rsp_if.sv
// ============================================================================
// bsp_rsp_if: result channel of the slot pool
// Valid/ready channel carrying one result per request.
// ============================================================================
interface bsp_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  slot_out;
    logic [5:0]  active_count;
    logic [31:0] open_descriptor_mask;
    logic [31:0] freed_mask;

    modport source (
        output valid, status, slot_out, active_count,
               open_descriptor_mask, freed_mask,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, active_count,
               open_descriptor_mask, freed_mask,
        output ready
    );

endinterface

FILE: rtl/bsp_slot_table.sv
// ============================================================================
// bsp_slot_table: per-slot state and descriptor storage
// One write port and one read port; reset returns every slot to free with
// no descriptor.
// ============================================================================
module bsp_slot_table #(
    parameter int unsigned SLOTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsp_pkg::tbl_wr_t      wr,
    input  bsp_pkg::slot_idx_t    rd_idx,
    output bsp_pkg::slot_state_t  rd_state,
    output bsp_pkg::desc_t        rd_desc
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    bsp_pkg::slot_state_t state_reg [SLOTS];
    bsp_pkg::desc_t       desc_reg  [SLOTS];

    logic [IW-1:0] wr_sel;
    logic [IW-1:0] rd_sel;

    assign wr_sel = wr.idx[IW-1:0];
    assign rd_sel = rd_idx[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                state_reg[i] <= bsp_pkg::SLOT_FREE;
                desc_reg[i]  <= bsp_pkg::DESC_NONE;
            end
        end
        else
        begin
            if (wr.we_state)
            begin
                state_reg[wr_sel] <= wr.state;
            end
            if (wr.we_desc)
            begin
                desc_reg[wr_sel] <= wr.desc;
            end
        end
    end

    assign rd_state = state_reg[rd_sel];
    assign rd_desc  = desc_reg[rd_sel];

endmodule

FILE: rtl/bitmask_slot_pool_with_fd_lookup.sv
// ============================================================================
// bitmask_slot_pool_with_fd_lookup: slot pool with bitmap and lowest-index scan
// Allocates, binds, flags, closes, sweeps and searches a pool of slots.
// ============================================================================
// Usage:
// Requests arrive on req (action, slot, descriptor and three flag values) and
// each one gives exactly one result on rsp. req.ready is high only while the
// sequencer is idle; one request is worked on at a time.
// Allocate, sweep and find walk the slots one per cycle, while no earlier
// result is held up on rsp, through a single compare step, starting at
// slot 0: allocate and find stop at the first hit, sweep always visits all
// SLOTS slots. Bind, set flags, close, count and the unused action finish
// in a single step. The scan rate is set by the single read port of the
// slot table. The result sits in an output register; the block accepts
// the next request while it waits. If rsp stalls with a result still held,
// the sequencer holds its current step until the output register frees up.
// Reset clears the active and flag bitmaps and the active count and returns
// every slot to free, descriptor -1; the block is ready right after reset.
// ============================================================================
module bitmask_slot_pool_with_fd_lookup #(
    parameter int unsigned SLOTS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    bsp_req_if.sink      req,
    bsp_rsp_if.source    rsp
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam bsp_pkg::slot_idx_t LAST_IDX = bsp_pkg::slot_idx_t'(SLOTS - 1);
    localparam logic [bsp_pkg::SLOT_W:0] SLOTS_C = (bsp_pkg::SLOT_W + 1)'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } fsm_t;

    fsm_t                       state_reg, state_next;
    bsp_pkg::action_t           act_reg, act_next;
    bsp_pkg::slot_idx_t         slot_reg, slot_next;
    bsp_pkg::desc_t             desc_reg, desc_next;
    logic                       wp_in_reg, wp_in_next;
    logic                       ws_in_reg, ws_in_next;
    logic                       rp_in_reg, rp_in_next;
    bsp_pkg::slot_idx_t         idx_reg, idx_next;
    logic [bsp_pkg::MASK_W-1:0] freed_reg, freed_next;
    logic [bsp_pkg::MASK_W-1:0] open_reg, open_next;
    logic [SLOTS-1:0]           active_reg, active_next;
    logic [SLOTS-1:0]           wp_bits_reg, wp_bits_next;
    logic [SLOTS-1:0]           ws_bits_reg, ws_bits_next;
    logic [SLOTS-1:0]           rp_bits_reg, rp_bits_next;
    logic [bsp_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                        out_valid_reg, out_valid_next;
    bsp_pkg::status_t            out_status_reg, out_status_next;
    bsp_pkg::slot_idx_t          out_slot_reg, out_slot_next;
    logic [bsp_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [bsp_pkg::MASK_W-1:0]  out_open_reg, out_open_next;
    logic [bsp_pkg::MASK_W-1:0]  out_freed_reg, out_freed_next;

    bsp_pkg::tbl_wr_t     tbl_wr;
    bsp_pkg::slot_state_t rd_state;
    bsp_pkg::desc_t       rd_desc;

    logic          can_finish;
    logic          finish;
    logic          last;
    logic          in_range;
    logic [IW-1:0] scan_sel;
    logic [IW-1:0] slot_sel;

    bsp_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_idx   (idx_reg),
        .rd_state (rd_state),
        .rd_desc  (rd_desc)
    );

    assign scan_sel   = idx_reg[IW-1:0];
    assign slot_sel   = slot_reg[IW-1:0];
    assign last       = (idx_reg == LAST_IDX);
    assign in_range   = ({1'b0, slot_reg} < SLOTS_C);
    assign can_finish = !out_valid_reg || rsp.ready;

    assign req.ready                = (state_reg == S_IDLE);
    assign rsp.valid                = out_valid_reg;
    assign rsp.status               = out_status_reg;
    assign rsp.slot_out             = out_slot_reg;
    assign rsp.active_count         = out_count_reg;
    assign rsp.open_descriptor_mask = out_open_reg;
    assign rsp.freed_mask           = out_freed_reg;

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        slot_next       = slot_reg;
        desc_next       = desc_reg;
        wp_in_next      = wp_in_reg;
        ws_in_next      = ws_in_reg;
        rp_in_next      = rp_in_reg;
        idx_next        = idx_reg;
        freed_next      = freed_reg;
        open_next       = open_reg;
        active_next     = active_reg;
        wp_bits_next    = wp_bits_reg;
        ws_bits_next    = ws_bits_reg;
        rp_bits_next    = rp_bits_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        out_open_next   = out_open_reg;
        out_freed_next  = out_freed_reg;
        tbl_wr          = '{we_state: 1'b0, we_desc: 1'b0, idx: idx_reg,
                            state: bsp_pkg::SLOT_FREE, desc: bsp_pkg::DESC_NONE};
        finish          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next   = bsp_pkg::action_t'(req.action);
                    slot_next  = req.slot;
                    desc_next  = req.descriptor;
                    wp_in_next = req.write_pending_in;
                    ws_in_next = req.ws_active_in;
                    rp_in_next = req.read_paused_in;
                    idx_next   = '0;
                    freed_next = '0;
                    open_next  = '0;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                // Every step waits while a previous result is still unclaimed.
                if (can_finish)
                begin
                    out_status_next = bsp_pkg::ST_OK;
                    out_slot_next   = '0;
                    unique case (act_reg)
                        bsp_pkg::ACT_ALLOC:
                        begin
                            if (!active_reg[scan_sel])
                            begin
                                tbl_wr.we_state = 1'b1;
                                tbl_wr.we_desc  = 1'b1;
                                tbl_wr.state    = bsp_pkg::SLOT_NEW;
                                active_next[scan_sel]  = 1'b1;
                                wp_bits_next[scan_sel] = 1'b0;
                                ws_bits_next[scan_sel] = 1'b0;
                                rp_bits_next[scan_sel] = 1'b0;
                                count_next    = count_reg + 1'b1;
                                out_slot_next = idx_reg;
                                finish        = 1'b1;
                            end
                            else if (last)
                            begin
                                out_status_next = bsp_pkg::ST_FULL;
                                finish          = 1'b1;
                            end
                        end
                        bsp_pkg::ACT_BIND, bsp_pkg::ACT_FLAGS, bsp_pkg::ACT_CLOSE:
                        begin
                            out_slot_next = slot_reg;
                            finish        = 1'b1;
                            tbl_wr.idx    = slot_reg;
                            if (!in_range)
                            begin
                                out_status_next = bsp_pkg::ST_BAD_INDEX;
                            end
                            else if (act_reg == bsp_pkg::ACT_BIND)
                            begin
                                tbl_wr.we_desc = 1'b1;
                                tbl_wr.desc    = desc_reg;
                            end
                            else if (act_reg == bsp_pkg::ACT_FLAGS)
                            begin
                                wp_bits_next[slot_sel] = wp_in_reg;
                                ws_bits_next[slot_sel] = ws_in_reg;
                                rp_bits_next[slot_sel] = rp_in_reg;
                            end
                            else
                            begin
                                tbl_wr.we_state = 1'b1;
                                tbl_wr.state    = bsp_pkg::SLOT_CLOSED;
                                wp_bits_next[slot_sel] = 1'b0;
                                ws_bits_next[slot_sel] = 1'b0;
                                rp_bits_next[slot_sel] = 1'b0;
                            end
                        end
                        bsp_pkg::ACT_SWEEP:
                        begin
                            if (active_reg[scan_sel] && rd_state == bsp_pkg::SLOT_CLOSED)
                            begin
                                tbl_wr.we_state = 1'b1;
                                tbl_wr.we_desc  = 1'b1;
                                active_next[scan_sel]  = 1'b0;
                                wp_bits_next[scan_sel] = 1'b0;
                                ws_bits_next[scan_sel] = 1'b0;
                                rp_bits_next[scan_sel] = 1'b0;
                                count_next          = count_reg - 1'b1;
                                freed_next[idx_reg] = 1'b1;
                                // A descriptor above zero was still open when freed.
                                open_next[idx_reg]  = (rd_desc != '0) && !rd_desc[15];
                            end
                            finish = last;
                        end
                        bsp_pkg::ACT_FIND:
                        begin
                            if (active_reg[scan_sel] && rd_desc == desc_reg)
                            begin
                                out_slot_next = idx_reg;
                                finish        = 1'b1;
                            end
                            else if (last)
                            begin
                                out_status_next = bsp_pkg::ST_MISSING;
                                finish          = 1'b1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase

                    if (finish)
                    begin
                        out_valid_next = 1'b1;
                        out_count_next = count_next;
                        out_open_next  = open_next;
                        out_freed_next = freed_next;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            wp_bits_reg   <= '0;
            ws_bits_reg   <= '0;
            rp_bits_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            wp_bits_reg   <= wp_bits_next;
            ws_bits_reg   <= ws_bits_next;
            rp_bits_reg   <= rp_bits_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        slot_reg       <= slot_next;
        desc_reg       <= desc_next;
        wp_in_reg      <= wp_in_next;
        ws_in_reg      <= ws_in_next;
        rp_in_reg      <= rp_in_next;
        idx_reg        <= idx_next;
        freed_reg      <= freed_next;
        open_reg       <= open_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
        out_open_reg   <= out_open_next;
        out_freed_reg  <= out_freed_next;
    end

endmodule
